>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TCPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define TCPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/tcpq_pkg.sv
// Package with the request and result types and constants of the two-class queue.
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;
  localparam int ID_FIELD_W   = 16;
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_SERVE    = 2'd1,
    MODE_WITHDRAW = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic [ID_FIELD_W-1:0]  id;
    logic                   is_priority;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic [ID_FIELD_W-1:0]    served_id;
    logic                     class_found;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } rsp_t;

  // Control that the top level broadcasts to every cell.
  typedef struct packed {
    logic                  cmp;       // compare the slots against id
    logic                  rm;        // close the gap behind the removed slot
    logic                  ins_prio;  // priority insert at the class boundary
    logic                  ins_norm;  // normal insert at the tail
    logic [ID_FIELD_W-1:0] id;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

endpackage

>>> hw/rtl/tcpq_cell.sv
// One queue slot: holds an id and its class, compares and shifts with its neighbors.
`timescale 1ns / 1ps

module tcpq_cell import tcpq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int ID_W  = ID_BITS_DEF,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CNT_W-1:0] pcount,
  input  logic [CNT_W-1:0] tcount,
  input  logic [ID_W-1:0]  left_id,
  input  logic             left_cls,
  input  logic [ID_W-1:0]  right_id,
  input  logic             right_cls,
  input  logic             chain_in,
  output logic             chain_out,
  output logic [ID_W-1:0]  slot_id,
  output logic             slot_cls,
  output logic             hit
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic occupied;

  assign occupied  = IDX_C < tcount;
  // A removal at or ahead of this slot pulls the right neighbor in.
  assign chain_out = chain_in | hit;

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit <= occupied && (slot_id == cmd.id[ID_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rm && chain_out) begin
      slot_id  <= right_id;
      slot_cls <= right_cls;
    end else if (cmd.ins_prio && (IDX_C > pcount)) begin
      slot_id  <= left_id;
      slot_cls <= left_cls;
    end else if ((cmd.ins_prio && (IDX_C == pcount)) ||
                 (cmd.ins_norm && (IDX_C == tcount))) begin
      slot_id  <= cmd.id[ID_W-1:0];
      slot_cls <= cmd.ins_prio;
    end
  end

endmodule

>>> hw/rtl/two_class_priority_queue_unit.sv
// Usage notes:
// A bounded queue of ids in two classes; priority entries are served before
// normal ones and each class is first in, first out. A request is given on
// req (mode, id, is_priority) with start high; it is taken at a rising edge
// where busy is low. Modes are insert, serve head, withdraw id and query.
// Every request gives exactly one result on rsp, valid for the single cycle
// in which done is high: ok, the served id, the class found and the count.
// Timing: the request edge compares every slot with the id in parallel and
// registers the hits; the next cycle (busy high) shifts the cell row and
// registers the result, which shows with done in the cycle after that. A
// new request may be started in the cycle where done is high. The update
// cycle is needed because the shift decision of the cell row uses the
// registered hit vector.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
// The receiver cannot stall: each result is taken in its done cycle.
`timescale 1ns / 1ps

module two_class_priority_queue_unit import tcpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

`include "assert_macros.svh"

  localparam int ID_W  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  state_t state, state_next;
  req_t   op;
  logic   accept;

  logic [CNT_W-1:0] total_count, total_count_next;
  logic [CNT_W-1:0] priority_count, priority_count_next;
  rsp_t             rsp_next;

  cell_cmd_t        cmd;
  logic [ID_W-1:0]  ids   [CAPACITY];
  logic             clss  [CAPACITY];
  logic             hits  [CAPACITY];
  logic             chain [CAPACITY+1];
  logic             found;
  logic             hit_cls;
  logic             upd;
  logic             ins_ok;
  logic             serve_ok;

  assign accept = start && !busy;
  assign upd    = (state == ST_UPD);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_UPD;
      ST_UPD:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    case (state)
      ST_UPD:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req;
    end
  end

  // Searches through the row: with no serve feeding the chain, its far end is the hit OR.
  assign chain[0] = (op.mode == MODE_SERVE);
  assign found    = chain[CAPACITY];

  always_comb begin
    hit_cls = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_cls = hit_cls | (hits[i] & clss[i]);
    end
  end

  assign ins_ok   = (op.mode == MODE_INSERT) && !found && (total_count < CAP_C);
  assign serve_ok = (op.mode == MODE_SERVE) && (total_count != '0);

  always_comb begin
    cmd.cmp      = accept;
    cmd.id       = accept ? req.id : op.id;
    cmd.rm       = upd && (serve_ok || ((op.mode == MODE_WITHDRAW) && found));
    cmd.ins_prio = upd && ins_ok && op.is_priority;
    cmd.ins_norm = upd && ins_ok && !op.is_priority;
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_W-1:0] l_id, r_id;
      logic            l_cls, r_cls;
      if (g == 0) begin : g_left_edge
        assign l_id  = ids[g];
        assign l_cls = clss[g];
      end else begin : g_left
        assign l_id  = ids[g-1];
        assign l_cls = clss[g-1];
      end
      if (g == CAPACITY - 1) begin : g_right_edge
        assign r_id  = ids[g];
        assign r_cls = clss[g];
      end else begin : g_right
        assign r_id  = ids[g+1];
        assign r_cls = clss[g+1];
      end
      tcpq_cell #(
        .IDX   (g),
        .ID_W  (ID_W),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .pcount    (priority_count),
        .tcount    (total_count),
        .left_id   (l_id),
        .left_cls  (l_cls),
        .right_id  (r_id),
        .right_cls (r_cls),
        .chain_in  (chain[g]),
        .chain_out (chain[g+1]),
        .slot_id   (ids[g]),
        .slot_cls  (clss[g]),
        .hit       (hits[g])
      );
    end
  endgenerate

  // Count updates and the result of the request in flight.
  always_comb begin
    total_count_next    = total_count;
    priority_count_next = priority_count;
    rsp_next            = '0;
    case (op.mode)
      MODE_INSERT: begin
        if (ins_ok) begin
          total_count_next = total_count + ONE_C;
          if (op.is_priority) begin
            priority_count_next = priority_count + ONE_C;
          end
          rsp_next.ok = 1'b1;
        end
      end
      MODE_SERVE: begin
        if (serve_ok) begin
          total_count_next = total_count - ONE_C;
          if (clss[0] && (priority_count != '0)) begin
            priority_count_next = priority_count - ONE_C;
          end
          rsp_next.ok          = 1'b1;
          rsp_next.served_id   = ID_FIELD_W'(ids[0]);
          rsp_next.class_found = clss[0];
        end
      end
      MODE_WITHDRAW: begin
        if (found) begin
          total_count_next = total_count - ONE_C;
          if (hit_cls && (priority_count != '0)) begin
            priority_count_next = priority_count - ONE_C;
          end
          rsp_next.ok = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (found) begin
          rsp_next.ok          = 1'b1;
          rsp_next.class_found = hit_cls;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    rsp_next.entry_count = COUNT_FIELD_W'(total_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count    <= '0;
      priority_count <= '0;
      done           <= 1'b0;
    end else begin
      done <= upd;
      if (upd) begin
        total_count    <= total_count_next;
        priority_count <= priority_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      rsp <= rsp_next;
    end
  end

  `TCPQ_ASSERT(a_class_bound, priority_count <= total_count, "priority count above total")
  `TCPQ_ASSERT(a_capacity, total_count <= CAP_C, "queue count above capacity")
  `TCPQ_ASSERT(a_done_after_upd, done |-> $past(busy), "result without an update cycle")
  `TCPQ_ASSERT(a_one_upd_cycle, busy |=> (!busy && done), "update did not finish in one cycle")
  `TCPQ_ASSERT(a_count_step, upd |=> ((total_count == $past(total_count)) || (total_count == $past(total_count) + ONE_C) || (total_count == $past(total_count) - ONE_C)), "count moved by more than one")

endmodule
